/* hdl/trie_root_word_replacer_defines.svh */
// ----------------------------------------------------------------------------
// trie_root_word_replacer_defines
// assertion macros shared by the trie root word replacer
// ----------------------------------------------------------------------------
`ifndef TRIE_ROOT_WORD_REPLACER_DEFINES_SVH
`define TRIE_ROOT_WORD_REPLACER_DEFINES_SVH

// condition holds in the same cycle
`define TRW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define TRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/trw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trw_pkg
// types and constants of the trie root word replacer
// ----------------------------------------------------------------------------
package trw_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int USED_W        = $clog2(NODE_COUNT + 1);
  localparam int COL_W         = $clog2(ALPHABET_SIZE);

  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DICT  = 2'd1;
  localparam logic [1:0] KIND_SENT  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

  typedef enum logic [1:0] {
    MODE_MATCH = 2'd0,
    MODE_ECHO  = 2'd1,
    MODE_DROP  = 2'd2
  } match_mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  // child pointer plus the end mark of that child
  typedef struct packed {
    logic              end_mark;
    logic [NODE_W-1:0] child;
  } entry_t;

  typedef entry_t [ALPHABET_SIZE-1:0] row_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic clear_step;
  } trw_cmd_t;

  typedef struct packed {
    logic out_stall;
    logic item_is_clear;
    logic clear_last;
  } trw_sts_t;

endpackage

/* hdl/trw_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trw_item_if
// input item channel: dictionary, sentence and clear items
// ----------------------------------------------------------------------------
interface trw_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] ch;
  logic       word_end;

  modport source (output valid, output kind, output ch, output word_end, input ready);
  modport sink (input valid, input kind, input ch, input word_end, output ready);
endinterface

/* hdl/trw_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trw_result_if
// result channel: echoed characters and dictionary word status
// ----------------------------------------------------------------------------
interface trw_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_status;
  logic [1:0] status;

  modport source (output valid, output out_char, output is_status, output status,
                  input ready);
  modport sink (input valid, input out_char, input is_status, input status,
                output ready);
endinterface

/* hdl/trw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trw_datapath
// node table memory, cursors, node allocation and the result register
// ----------------------------------------------------------------------------
module trw_datapath (
  input  logic              clk,
  input  logic              rst,
  input  trw_pkg::trw_cmd_t cmd,
  output trw_pkg::trw_sts_t sts,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_ch,
  input  logic              in_word_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_is_status,
  output logic [1:0]        out_status
);
  import trw_pkg::*;

  row_t              mem [NODE_COUNT];
  row_t              rd_row;

  logic [1:0]        item_kind;
  logic [7:0]        item_ch;
  logic              item_end;

  logic [USED_W-1:0] nodes_used;
  logic [USED_W-1:0] nodes_used_next;
  logic [NODE_W-1:0] insert_cursor;
  logic [NODE_W-1:0] insert_cursor_next;
  logic [1:0]        insert_error;
  logic [1:0]        insert_error_next;
  logic [NODE_W-1:0] match_cursor;
  logic [NODE_W-1:0] match_cursor_next;
  match_mode_t       match_mode;
  match_mode_t       match_mode_next;
  logic [NODE_W-1:0] clr_row;

  logic              is_letter;
  logic [COL_W-1:0]  col;
  logic [7:0]        ch_off;
  entry_t            sel;
  logic              wr_en;
  entry_t            wr_data;
  logic              res_valid;
  logic              res_is_status;
  logic [1:0]        res_status;

  assign ch_off    = item_ch - CHAR_A;
  assign is_letter = (item_ch >= CHAR_A) && (ch_off < 8'(ALPHABET_SIZE));
  assign col       = ch_off[COL_W-1:0];
  assign sel       = is_letter ? rd_row[col] : '0;

  always_comb begin
    nodes_used_next    = nodes_used;
    insert_cursor_next = insert_cursor;
    insert_error_next  = insert_error;
    match_cursor_next  = match_cursor;
    match_mode_next    = match_mode;
    wr_en              = 1'b0;
    wr_data            = '0;
    res_valid          = 1'b0;
    res_is_status      = 1'b0;
    res_status         = STATUS_OK;
    case (item_kind)
      KIND_CLEAR: begin
        nodes_used_next    = USED_W'(1);
        insert_cursor_next = '0;
        insert_error_next  = STATUS_OK;
        match_cursor_next  = '0;
        match_mode_next    = MODE_MATCH;
      end
      KIND_DICT: begin
        if (insert_error == STATUS_OK) begin
          if (!is_letter) begin
            insert_error_next = STATUS_BAD_CHAR;
          end else if (sel.child == '0) begin
            if (nodes_used < USED_W'(NODE_COUNT)) begin
              nodes_used_next    = nodes_used + USED_W'(1);
              insert_cursor_next = nodes_used[NODE_W-1:0];
              wr_en              = 1'b1;
              wr_data.child      = nodes_used[NODE_W-1:0];
              wr_data.end_mark   = item_end;
            end else begin
              insert_error_next = STATUS_FULL;
            end
          end else begin
            insert_cursor_next = sel.child;
            // word ends on an existing node: set its mark
            if (item_end) begin
              wr_en            = 1'b1;
              wr_data.child    = sel.child;
              wr_data.end_mark = 1'b1;
            end
          end
        end
        if (item_end) begin
          res_valid          = 1'b1;
          res_is_status      = 1'b1;
          res_status         = insert_error_next;
          insert_cursor_next = '0;
          insert_error_next  = STATUS_OK;
        end
      end
      KIND_SENT: begin
        res_valid = 1'b1;
        if (item_ch == CHAR_SPACE) begin
          match_cursor_next = '0;
          match_mode_next   = MODE_MATCH;
        end else if (match_mode == MODE_DROP) begin
          res_valid = 1'b0;
        end else if (match_mode == MODE_MATCH) begin
          if (is_letter && (sel.child != '0)) begin
            match_cursor_next = sel.child;
            match_mode_next   = sel.end_mark ? MODE_DROP : MODE_MATCH;
          end else begin
            match_mode_next = MODE_ECHO;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // node table: row read at accept, one entry written at commit, rows wiped by the sweep
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_row <= mem[(in_kind == KIND_DICT) ? insert_cursor : match_cursor];
    end
    if (cmd.clear_step) begin
      mem[clr_row] <= '0;
    end else if (cmd.commit && wr_en) begin
      mem[insert_cursor][col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind <= in_kind;
      item_ch   <= in_ch;
      item_end  <= in_word_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used    <= USED_W'(1);
      insert_cursor <= '0;
      insert_error  <= STATUS_OK;
      match_cursor  <= '0;
      match_mode    <= MODE_MATCH;
      clr_row       <= '0;
    end else begin
      if (cmd.commit) begin
        nodes_used    <= nodes_used_next;
        insert_cursor <= insert_cursor_next;
        insert_error  <= insert_error_next;
        match_cursor  <= match_cursor_next;
        match_mode    <= match_mode_next;
      end
      if (cmd.commit && (item_kind == KIND_CLEAR)) begin
        clr_row <= '0;
      end else if (cmd.clear_step) begin
        clr_row <= sts.clear_last ? '0 : clr_row + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && res_valid) begin
      out_char      <= res_is_status ? 8'd0 : item_ch;
      out_is_status <= res_is_status;
      out_status    <= res_status;
    end
  end

  assign sts.out_stall     = out_valid && !out_ready;
  assign sts.item_is_clear = (item_kind == KIND_CLEAR);
  assign sts.clear_last    = (clr_row == NODE_W'(NODE_COUNT - 1));

endmodule

/* hdl/trw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trw_ctrl
// sequencer: table sweep, item accept, evaluate and commit
// ----------------------------------------------------------------------------
module trw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trw_pkg::trw_sts_t sts,
  output trw_pkg::trw_cmd_t cmd
);
  import trw_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.out_stall) state_next = sts.item_is_clear ? ST_CLEAR : ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.commit     = 1'b0;
    cmd.clear_step = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      // hold the item while the result register cannot take a new transfer
      ST_EXEC: cmd.commit = !sts.out_stall;
      default: begin
      end
    endcase
  end

endmodule

/* hdl/trie_root_word_replacer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_root_word_replacer
// dictionary trie with shortest root replacement of streamed sentence words
// ----------------------------------------------------------------------------
// Each accepted item is read, then evaluated: the accept cycle reads one row of
// the single-port node table, the EXEC state after it evaluates that row and
// writes at most one child entry once the result register has room; the next
// item is taken in IDLE after that. After reset and after every clear item all
// NODE_COUNT (1024) node table rows are swept one row per cycle, with the input
// held not ready. A finished result waits in an output register; an item only
// stalls in its EXEC state when that register is still full and not being taken.
// ----------------------------------------------------------------------------
`include "trie_root_word_replacer_defines.svh"

module trie_root_word_replacer (
  input logic         clk,
  input logic         rst,
  trw_item_if.sink    item,
  trw_result_if.source result
);
  import trw_pkg::*;

  trw_cmd_t cmd;
  trw_sts_t sts;

  trw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trw_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (item.kind),
    .in_ch         (item.ch),
    .in_word_end   (item.word_end),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_char      (result.out_char),
    .out_is_status (result.is_status),
    .out_status    (result.status)
  );

  `TRW_ASSERT_NOW(a_no_accept_in_sweep, cmd.clear_step, !item.ready, "item taken during table sweep")
  `TRW_ASSERT_NOW(a_commit_needs_room, cmd.commit, !sts.out_stall, "commit while result register full")
  `TRW_ASSERT_NEXT(a_one_item_at_a_time, item.valid && item.ready, !item.ready && !cmd.clear_step, "second item taken before commit")

endmodule

/* tb/trie_root_word_replacer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_root_word_replacer_test
// self-checking bench for the trie root word replacer: a short table of
// hand-picked items, a pass that fills the node pool, then random phases of
// dictionary words and sentences; results are predicted by a trie model kept
// here, apart from the table rows that carry their own expected result
module trie_root_word_replacer_test;
  import trw_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam bit         TYPED       = 1'b1;
  localparam bit         PRED        = 1'b0;
  localparam int         WORD_SLOTS  = 16;
  localparam int         RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       word_end;
  } trie_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_status;
    logic [1:0] status;
  } trie_out_t;

  typedef struct packed {
    trie_item_t stim;
    logic       typed;
    trie_out_t  want;
  } dir_row_t;

  localparam trie_out_t NO_WANT = '0;

  logic clk;
  logic rst;

  trw_item_if   item_ch();
  trw_result_if result_ch();

  trie_root_word_replacer u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // trie model state
  logic [NODE_W-1:0] trie_child [NODE_COUNT*ALPHABET_SIZE];
  bit                trie_end   [NODE_COUNT];
  int unsigned       trie_nodes_used;
  logic [NODE_W-1:0] ins_node;
  logic [1:0]        ins_err;
  logic [NODE_W-1:0] walk_node;
  match_mode_t       walk_mode;

  trie_out_t pending_out[$];
  int        fail_count;
  int        item_total;
  int        burst_left;
  bit        long_hold_req;
  logic      drive_typed;
  trie_out_t drive_want;

  logic [7:0] word_buf [0:WORD_SLOTS-1][0:31];
  int         word_len [0:WORD_SLOTS-1];
  int         word_cnt;

  dir_row_t directed_rows [0:24] = '{
    {KIND_SENT,   "a",   1'b0, TYPED, {"a", 1'b0, STATUS_OK}},
    {KIND_SENT,   8'hff, 1'b1, TYPED, {8'hff, 1'b0, STATUS_OK}},
    {KIND_SENT,   8'h00, 1'b0, TYPED, {8'h00, 1'b0, STATUS_OK}},
    {KIND_SENT,   " ",   1'b0, TYPED, {" ", 1'b0, STATUS_OK}},
    {KIND_DICT,   "c",   1'b0, PRED,  NO_WANT},
    {KIND_DICT,   "a",   1'b0, PRED,  NO_WANT},
    {KIND_DICT,   "t",   1'b1, TYPED, {8'h00, 1'b1, STATUS_OK}},
    // shorter root on the same path
    {KIND_DICT,   "c",   1'b1, TYPED, {8'h00, 1'b1, STATUS_OK}},
    {KIND_SENT,   "c",   1'b0, PRED,  NO_WANT},
    {KIND_SENT,   "a",   1'b0, PRED,  NO_WANT},
    {KIND_SENT,   "t",   1'b1, PRED,  NO_WANT},
    // odd byte inside a word that is already dropped
    {KIND_SENT,   8'hff, 1'b0, PRED,  NO_WANT},
    {KIND_SENT,   " ",   1'b0, TYPED, {" ", 1'b0, STATUS_OK}},
    {KIND_SENT,   "d",   1'b0, PRED,  NO_WANT},
    {KIND_DICT,   "{",   1'b1, TYPED, {8'h00, 1'b1, STATUS_BAD_CHAR}},
    // error first, then a good letter that must be ignored
    {KIND_DICT,   8'h60, 1'b0, PRED,  NO_WANT},
    {KIND_DICT,   "a",   1'b1, TYPED, {8'h00, 1'b1, STATUS_BAD_CHAR}},
    {KIND_DICT,   "z",   1'b1, TYPED, {8'h00, 1'b1, STATUS_OK}},
    {KIND_DICT,   8'h80, 1'b1, TYPED, {8'h00, 1'b1, STATUS_BAD_CHAR}},
    {KIND_UNUSED, "z",   1'b1, PRED,  NO_WANT},
    {KIND_SENT,   " ",   1'b0, TYPED, {" ", 1'b0, STATUS_OK}},
    {KIND_SENT,   "z",   1'b0, PRED,  NO_WANT},
    {KIND_SENT,   "a",   1'b0, PRED,  NO_WANT},
    {KIND_CLEAR,  8'hff, 1'b1, PRED,  NO_WANT},
    {KIND_SENT,   "z",   1'b0, TYPED, {"z", 1'b0, STATUS_OK}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CHAR_A) && (c < CHAR_A + ALPHABET_SIZE);
  endfunction

  function automatic void trie_clear();
    foreach (trie_child[i]) trie_child[i] = '0;
    foreach (trie_end[i]) trie_end[i] = 1'b0;
    trie_nodes_used = 1;
    ins_node        = '0;
    ins_err         = STATUS_OK;
    walk_node       = '0;
    walk_mode       = MODE_MATCH;
  endfunction

  // advances the trie model by one item, returns 1 when a result is due
  function automatic bit trie_step(input trie_item_t it, output trie_out_t res);
    logic [NODE_W-1:0] nxt;
    int                idx;
    res = '0;
    case (it.kind)
      KIND_CLEAR: begin
        trie_clear();
        return 1'b0;
      end
      KIND_DICT: begin
        if (ins_err == STATUS_OK) begin
          if (!is_letter(it.ch)) begin
            ins_err = STATUS_BAD_CHAR;
          end else begin
            idx = ins_node * ALPHABET_SIZE + (it.ch - CHAR_A);
            nxt = trie_child[idx];
            if (nxt == '0) begin
              if (trie_nodes_used < NODE_COUNT) begin
                nxt = trie_nodes_used[NODE_W-1:0];
                trie_nodes_used++;
                trie_child[idx] = nxt;
              end else begin
                ins_err = STATUS_FULL;
              end
            end
            if (ins_err == STATUS_OK) ins_node = nxt;
          end
        end
        if (!it.word_end) return 1'b0;
        if (ins_err == STATUS_OK) trie_end[ins_node] = 1'b1;
        res.is_status = 1'b1;
        res.status    = ins_err;
        ins_node      = '0;
        ins_err       = STATUS_OK;
        return 1'b1;
      end
      KIND_SENT: begin
        res.out_char = it.ch;
        if (it.ch == CHAR_SPACE) begin
          walk_node = '0;
          walk_mode = MODE_MATCH;
          return 1'b1;
        end
        if (walk_mode == MODE_DROP) return 1'b0;
        if (walk_mode == MODE_MATCH) begin
          nxt = is_letter(it.ch) ? trie_child[walk_node * ALPHABET_SIZE + (it.ch - CHAR_A)]
                                 : '0;
          if (nxt == '0) begin
            walk_mode = MODE_ECHO;
          end else begin
            walk_node = nxt;
            if (trie_end[nxt]) walk_mode = MODE_DROP;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // predicts on every input transfer, checks every output transfer
  always @(posedge clk) begin : scoreboard
    trie_out_t pred;
    trie_out_t want;
    trie_out_t got;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        if (trie_step({item_ch.kind, item_ch.ch, item_ch.word_end}, pred))
          pending_out.insert(pending_out.size(), drive_typed ? drive_want : pred);
      end
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.out_char, result_ch.is_status, result_ch.status};
        if (pending_out.size() == 0) begin
          $error("result transfer with nothing pending: out_char %0d is_status %0d status %0d",
                 got.out_char, got.is_status, got.status);
          fail_count++;
        end else begin
          want = pending_out.pop_front();
          compare_field("out_char", want.out_char, got.out_char);
          compare_field("is_status", want.is_status, got.is_status);
          compare_field("status", want.status, got.status);
        end
      end
    end
  end

  // receiver: stall density changes per segment, plus one long hold-off
  initial begin : receiver
    int seg_left;
    int stall_pct;
    int hold_left;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 300;
        result_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      @(posedge clk);
    end
  end

  task automatic send_item(input trie_item_t it, input logic typed, input trie_out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    item_ch.valid    <= 1'b1;
    item_ch.kind     <= it.kind;
    item_ch.ch       <= it.ch;
    item_ch.word_end <= it.word_end;
    drive_typed      <= typed;
    drive_want       <= want;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    burst_left--;
    if (it.kind != KIND_UNUSED) item_total++;
  endtask

  task automatic put(input logic [1:0] kind, input logic [7:0] ch, input logic word_end);
    send_item({kind, ch, word_end}, PRED, NO_WANT);
  endtask

  // holds the input idle until every pending result has come out
  task automatic drain();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] letter(input int alpha);
    return CHAR_A + 8'($urandom_range(0, alpha - 1));
  endfunction

  function automatic logic [7:0] odd_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_letter(b) || b == CHAR_SPACE);
    return b;
  endfunction

  task automatic send_dict_word(input int alpha, input int min_len, input int max_len,
                                input bit may_break);
    int         len;
    int         bad_pos;
    int         slot;
    logic [7:0] c;
    len     = $urandom_range(min_len, max_len);
    bad_pos = (may_break && $urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
    slot    = word_cnt % WORD_SLOTS;
    for (int i = 0; i < len; i++) begin
      c = (i == bad_pos) ? odd_byte() : letter(alpha);
      word_buf[slot][i] = c;
      put(KIND_DICT, c, i == len - 1);
    end
    if (bad_pos < 0) begin
      word_len[slot] = len;
      word_cnt++;
    end
  endtask

  // one sentence word, mostly built on a known root, followed by its space
  task automatic send_sentence_word(input int alpha);
    logic [7:0] chars [0:40];
    int         blen;
    int         w;
    int         n;
    int         bad_pos;
    blen = 0;
    if (word_cnt != 0 && $urandom_range(0, 9) < 6) begin
      w = $urandom_range(0, (word_cnt < WORD_SLOTS ? word_cnt : WORD_SLOTS) - 1);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, word_len[w]) : word_len[w];
      for (int i = 0; i < n; i++) chars[blen++] = word_buf[w][i];
      n = $urandom_range(0, 4);
    end else begin
      n = $urandom_range(1, 6);
    end
    repeat (n) chars[blen++] = letter(alpha);
    bad_pos = ($urandom_range(0, 11) == 0) ? $urandom_range(0, blen - 1) : -1;
    for (int i = 0; i < blen; i++) begin
      if (i == bad_pos) put(KIND_SENT, odd_byte(), 1'($urandom_range(0, 1)));
      put(KIND_SENT, chars[i], 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 3)
        put(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 2) send_dict_word(alpha, 1, 4, 1'b1);
    end
    put(KIND_SENT, CHAR_SPACE, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) put(KIND_SENT, CHAR_SPACE, 1'b0);
  endtask

  initial begin : stimulus
    int start_total;
    int alpha;
    int phase;
    fail_count    = 0;
    item_total    = 0;
    burst_left    = 0;
    word_cnt      = 0;
    long_hold_req = 1'b0;
    trie_clear();
    rst              <= 1'b1;
    item_ch.valid    <= 1'b0;
    item_ch.kind     <= KIND_CLEAR;
    item_ch.ch       <= '0;
    item_ch.word_end <= 1'b0;
    drive_typed      <= 1'b0;
    drive_want       <= NO_WANT;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    // fill the node pool, then push past it
    put(KIND_CLEAR, 8'h00, 1'b0);
    word_cnt = 0;
    while (trie_nodes_used < NODE_COUNT) send_dict_word(ALPHABET_SIZE, 8, 30, 1'b0);
    repeat (3) send_dict_word(ALPHABET_SIZE, 2, 6, 1'b0);
    repeat (4) send_sentence_word(ALPHABET_SIZE);
    drain();

    start_total = item_total;
    phase       = 0;
    while (item_total - start_total < RANDOM_ITEMS) begin
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        put(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        word_cnt = 0;
      end
      alpha = ($urandom_range(0, 2) == 0) ? ALPHABET_SIZE : $urandom_range(2, 4);
      repeat ($urandom_range(1, 6)) send_dict_word(alpha, 1, ($urandom_range(0, 4) == 0) ? 8 : 4,
                                                   1'b1);
      // receiver holds off while the sender keeps offering
      if (phase == 1) long_hold_req = 1'b1;
      repeat ($urandom_range(3, 12)) send_sentence_word(alpha);
      if (phase % 4 == 2) drain();
      phase++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("trie_root_word_replacer test passed");
    end else begin
      $display("trie_root_word_replacer test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("trie_root_word_replacer test failed");
    $finish;
  end

endmodule
